FILE: rtl/sjf_pkg.sv
// Shared types and field widths for the shortest-job-first scheduler.
`timescale 1ns / 1ps
`default_nettype none

package sjf_pkg;

	localparam int IN_TIME_W = 16;
	localparam int PNUM_W    = 5;
	localparam int TIME_W    = 21;
	localparam int AVG_W     = 29;
	localparam int SUM_W     = 25;
	localparam int FRAC_W    = 8;
	localparam int DVD_W     = SUM_W + FRAC_W;
	localparam int DSTEP_W   = $clog2(DVD_W);

	typedef struct packed {
		logic [IN_TIME_W-1:0] arrival_time;
		logic [IN_TIME_W-1:0] burst_time;
		logic                 last_process;
	} job_t;

	typedef struct packed {
		logic [PNUM_W-1:0] process_number;
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] waiting_time;
		logic [TIME_W-1:0] turnaround_time;
		logic [AVG_W-1:0]  avg_waiting_q8;
		logic [AVG_W-1:0]  avg_turnaround_q8;
		logic              last_result;
	} sched_t;

endpackage

`default_nettype wire

FILE: rtl/sjf_nonpreemptive_scheduler_core.sv
// Top level: loads a process set and emits a non-preemptive shortest-job-first schedule.
// Loading takes one word per cycle while job_ready is high, which is only in the load
// state; a word without last_process produces no result. Each pick is one linear scan of
// the n loaded entries through a single store read port. The final result waits for the two
// averages, done one quotient bit per cycle on a shared restoring divider. Reset clears all
// control state; the stores hold no reset value and only entries loaded for the current set
// are ever read.
`timescale 1ns / 1ps
`default_nettype none

module sjf_nonpreemptive_scheduler_core #(
	parameter int MAX_PROCS = 16,
	parameter int TIME_BITS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           job_valid,
	output logic                job_ready,
	input  wire sjf_pkg::job_t  job,
	output logic                sched_valid,
	input  wire logic           sched_ready,
	output sjf_pkg::sched_t     sched
);

	localparam int IDX_W = $clog2(MAX_PROCS);
	localparam int CNT_W = $clog2(MAX_PROCS + 1);
	localparam int CT_W  = TIME_BITS + $clog2(MAX_PROCS) + 1;
	localparam int TW    = TIME_BITS;
	localparam int OTW   = sjf_pkg::TIME_W;
	localparam int PW    = sjf_pkg::PNUM_W;
	localparam int SW    = sjf_pkg::SUM_W;
	localparam int AW    = sjf_pkg::AVG_W;
	localparam int DW    = sjf_pkg::DVD_W;
	localparam int DSW   = sjf_pkg::DSTEP_W;
	localparam int FW    = sjf_pkg::FRAC_W;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_COMMIT,
		ST_DIV
	} state_t;

	state_t state_q;

	// Process stores: one write port for loading, one registered read port for the scan.
	logic [TW-1:0] arr_mem [MAX_PROCS];
	logic [TW-1:0] bst_mem [MAX_PROCS];
	logic [TW-1:0] arr_s1;
	logic [TW-1:0] bst_s1;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] issue_idx_q;
	logic [CNT_W-1:0] picks_q;
	logic             scan_v_s1;
	logic             last_s1;
	logic [IDX_W-1:0] idx_s1;

	logic [MAX_PROCS-1:0] done_q;
	logic [CT_W-1:0]      time_q;
	logic [SW-1:0]        wsum_q;
	logic [SW-1:0]        tsum_q;

	// Best ready candidate (burst, arrival, index) and earliest pending one (arrival, burst, index).
	logic             rbest_v_q;
	logic [IDX_W-1:0] rbest_idx_q;
	logic [TW-1:0]    rbest_arr_q;
	logic [TW-1:0]    rbest_bst_q;
	logic             pbest_v_q;
	logic [IDX_W-1:0] pbest_idx_q;
	logic [TW-1:0]    pbest_arr_q;
	logic [TW-1:0]    pbest_bst_q;

	logic [DW-1:0]    dvd_q;
	logic [CNT_W-1:0] rem_q;
	logic [DSW-1:0]   div_cnt_q;
	logic             div_sel_q;

	logic             issuing;
	logic             cand_done;
	logic             cand_ready;
	logic             better_r;
	logic             better_p;
	logic [IDX_W-1:0] sel_idx;
	logic [TW-1:0]    sel_arr;
	logic [TW-1:0]    sel_bst;
	logic [CT_W-1:0]  start_ct;
	logic [CT_W-1:0]  wait_ct;
	logic [CT_W-1:0]  fin_ct;
	logic [CT_W-1:0]  tat_ct;
	logic [SW-1:0]    wsum_nxt;
	logic [SW-1:0]    tsum_nxt;
	logic             out_free;
	logic             last_pick;
	logic [CNT_W:0]   rem_sh;
	logic             q_bit;
	logic [CNT_W-1:0] rem_nxt;
	logic [DW-1:0]    dvd_nxt;

	assign job_ready = (state_q == ST_LOAD);
	assign issuing   = (state_q == ST_SCAN) && (issue_idx_q < n_q);

	assign cand_done  = done_q[idx_s1];
	assign cand_ready = !cand_done && (CT_W'(arr_s1) <= time_q);
	assign better_r   = !rbest_v_q || (bst_s1 < rbest_bst_q) ||
		((bst_s1 == rbest_bst_q) && (arr_s1 < rbest_arr_q));
	assign better_p   = !pbest_v_q || (arr_s1 < pbest_arr_q) ||
		((arr_s1 == pbest_arr_q) && (bst_s1 < pbest_bst_q));

	// With nothing ready, the processor idles to the earliest arrival and runs that process.
	assign sel_idx  = rbest_v_q ? rbest_idx_q : pbest_idx_q;
	assign sel_arr  = rbest_v_q ? rbest_arr_q : pbest_arr_q;
	assign sel_bst  = rbest_v_q ? rbest_bst_q : pbest_bst_q;
	assign start_ct = rbest_v_q ? time_q : CT_W'(pbest_arr_q);
	assign wait_ct  = start_ct - CT_W'(sel_arr);
	assign fin_ct   = start_ct + CT_W'(sel_bst);
	assign tat_ct   = fin_ct - CT_W'(sel_arr);
	assign wsum_nxt = wsum_q + SW'(wait_ct);
	assign tsum_nxt = tsum_q + SW'(tat_ct);

	assign out_free  = !sched_valid || sched_ready;
	assign last_pick = (picks_q == n_q - CNT_W'(1));

	// One restoring divide step per cycle; the quotient shifts into the dividend register.
	assign rem_sh  = {rem_q, dvd_q[DW-1]};
	assign q_bit   = (rem_sh >= {1'b0, n_q});
	assign rem_nxt = q_bit ? CNT_W'(rem_sh - {1'b0, n_q}) : CNT_W'(rem_sh);
	assign dvd_nxt = {dvd_q[DW-2:0], q_bit};

	always_ff @(posedge clk) begin
		if (job_ready && job_valid && (cnt_q < CNT_W'(MAX_PROCS))) begin
			arr_mem[cnt_q[IDX_W-1:0]] <= TW'(job.arrival_time);
			bst_mem[cnt_q[IDX_W-1:0]] <= TW'(job.burst_time);
		end
		arr_s1 <= arr_mem[issue_idx_q[IDX_W-1:0]];
		bst_s1 <= bst_mem[issue_idx_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			n_q         <= '0;
			issue_idx_q <= '0;
			picks_q     <= '0;
			scan_v_s1   <= 1'b0;
			last_s1     <= 1'b0;
			idx_s1      <= '0;
			done_q      <= '0;
			time_q      <= '0;
			wsum_q      <= '0;
			tsum_q      <= '0;
			rbest_v_q   <= 1'b0;
			rbest_idx_q <= '0;
			rbest_arr_q <= '0;
			rbest_bst_q <= '0;
			pbest_v_q   <= 1'b0;
			pbest_idx_q <= '0;
			pbest_arr_q <= '0;
			pbest_bst_q <= '0;
			dvd_q       <= '0;
			rem_q       <= '0;
			div_cnt_q   <= '0;
			div_sel_q   <= 1'b0;
			sched_valid <= 1'b0;
			sched       <= '0;
		end else begin
			scan_v_s1 <= issuing;
			last_s1   <= (issue_idx_q == n_q - CNT_W'(1));
			idx_s1    <= issue_idx_q[IDX_W-1:0];
			if (sched_valid && sched_ready) begin
				sched_valid <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (job_valid) begin
						if (cnt_q < CNT_W'(MAX_PROCS)) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
						if (job.last_process) begin
							n_q         <= (cnt_q < CNT_W'(MAX_PROCS)) ?
								cnt_q + CNT_W'(1) : cnt_q;
							state_q     <= ST_SCAN;
							issue_idx_q <= '0;
							rbest_v_q   <= 1'b0;
							pbest_v_q   <= 1'b0;
							done_q      <= '0;
							time_q      <= '0;
							wsum_q      <= '0;
							tsum_q      <= '0;
							picks_q     <= '0;
						end
					end
				end
				ST_SCAN: begin
					if (issuing) begin
						issue_idx_q <= issue_idx_q + CNT_W'(1);
					end
					if (scan_v_s1) begin
						if (cand_ready && better_r) begin
							rbest_v_q   <= 1'b1;
							rbest_idx_q <= idx_s1;
							rbest_arr_q <= arr_s1;
							rbest_bst_q <= bst_s1;
						end
						if (!cand_done && better_p) begin
							pbest_v_q   <= 1'b1;
							pbest_idx_q <= idx_s1;
							pbest_arr_q <= arr_s1;
							pbest_bst_q <= bst_s1;
						end
						if (last_s1) begin
							state_q <= ST_COMMIT;
						end
					end
				end
				ST_COMMIT: begin
					if (out_free) begin
						done_q[sel_idx]         <= 1'b1;
						time_q                  <= fin_ct;
						wsum_q                  <= wsum_nxt;
						tsum_q                  <= tsum_nxt;
						picks_q                 <= picks_q + CNT_W'(1);
						sched.process_number    <= PW'(sel_idx) + PW'(1);
						sched.start_time        <= OTW'(start_ct);
						sched.waiting_time      <= OTW'(wait_ct);
						sched.turnaround_time   <= OTW'(tat_ct);
						sched.avg_waiting_q8    <= '0;
						sched.avg_turnaround_q8 <= '0;
						sched.last_result       <= 1'b0;
						if (last_pick) begin
							// The final word waits for both averages before it is shown.
							state_q   <= ST_DIV;
							dvd_q     <= {wsum_nxt, {FW{1'b0}}};
							rem_q     <= '0;
							div_cnt_q <= '0;
							div_sel_q <= 1'b0;
						end else begin
							sched_valid <= 1'b1;
							state_q     <= ST_SCAN;
							issue_idx_q <= '0;
							rbest_v_q   <= 1'b0;
							pbest_v_q   <= 1'b0;
						end
					end
				end
				ST_DIV: begin
					dvd_q     <= dvd_nxt;
					rem_q     <= rem_nxt;
					div_cnt_q <= div_cnt_q + DSW'(1);
					if (div_cnt_q == DSW'(DW - 1)) begin
						if (!div_sel_q) begin
							sched.avg_waiting_q8 <= AW'(dvd_nxt);
							dvd_q                <= {tsum_q, {FW{1'b0}}};
							rem_q                <= '0;
							div_cnt_q            <= '0;
							div_sel_q            <= 1'b1;
						end else begin
							sched.avg_turnaround_q8 <= AW'(dvd_nxt);
							sched.last_result       <= 1'b1;
							sched_valid             <= 1'b1;
							cnt_q                   <= '0;
							state_q                 <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (issue_idx_q <= n_q))
		else $error("scan index ran past the loaded count");

	a_commit_has_pick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT) |-> pbest_v_q)
		else $error("pick committed with no pending process");

	a_done_matches_picks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ($countones(done_q) == int'(picks_q)))
		else $error("done flags disagree with the number of picks");

	a_ready_pick_arrived: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_COMMIT) && rbest_v_q) |-> (CT_W'(rbest_arr_q) <= time_q))
		else $error("ready pick has not yet arrived");

	a_avg_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		(sched_valid && !sched.last_result) |->
		((sched.avg_waiting_q8 == '0) && (sched.avg_turnaround_q8 == '0)))
		else $error("averages shown on a word that is not final");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/sjf_schedule_checker.sv
// Checker that predicts the shortest-job-first schedule and compares every emitted word.
`timescale 1ns / 1ps

module sjf_schedule_checker (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            job_valid,
	input  wire logic            job_ready,
	input  wire sjf_pkg::job_t   job,
	input  wire logic            sched_valid,
	input  wire logic            sched_ready,
	input  wire sjf_pkg::sched_t sched,
	output int                   fail_count,
	output int                   pending,
	output int                   checked
);

	localparam int NPROC = 16;
	localparam int REPORT_LIMIT = 10;
	localparam int TW = sjf_pkg::IN_TIME_W;
	localparam int PNW = sjf_pkg::PNUM_W;
	localparam int OTW = sjf_pkg::TIME_W;
	localparam int AVW = sjf_pkg::AVG_W;
	localparam int SMW = sjf_pkg::SUM_W;
	localparam int FRW = sjf_pkg::FRAC_W;

	logic [TW-1:0] arr_q [NPROC];
	logic [TW-1:0] burst_q [NPROC];
	int held;
	sjf_pkg::sched_t schedule_q [$];
	int errs;
	int words_checked;

	function automatic int best_ready(logic [NPROC-1:0] ran, logic [31:0] now);
		int best;
		best = -1;
		for (int i = 0; i < held; i++) begin
			if (!ran[i] && 32'(arr_q[i]) <= now) begin
				if (best < 0 || burst_q[i] < burst_q[best] ||
				    (burst_q[i] == burst_q[best] && arr_q[i] < arr_q[best]))
					best = i;
			end
		end
		return best;
	endfunction

	// Builds the whole run for the held set and queues one word per process.
	task automatic plan_schedule();
		logic [NPROC-1:0] ran;
		logic [31:0] now, start_t, wait_t, tat_t;
		logic [SMW-1:0] wsum, tsum;
		int pick;
		sjf_pkg::sched_t r;
		ran = '0;
		now = '0;
		wsum = '0;
		tsum = '0;
		for (int k = 0; k < held; k++) begin
			r = '0;
			pick = best_ready(ran, now);
			if (pick < 0) begin
				// Nothing has arrived yet, so the processor sits idle until the next arrival.
				now = 32'hFFFF_FFFF;
				for (int i = 0; i < held; i++)
					if (!ran[i] && 32'(arr_q[i]) < now)
						now = 32'(arr_q[i]);
				pick = best_ready(ran, now);
			end
			start_t = now;
			wait_t = start_t - 32'(arr_q[pick]);
			now = start_t + 32'(burst_q[pick]);
			tat_t = now - 32'(arr_q[pick]);
			ran[pick] = 1'b1;
			wsum = wsum + SMW'(wait_t);
			tsum = tsum + SMW'(tat_t);
			r.process_number = PNW'(pick + 1);
			r.start_time = OTW'(start_t);
			r.waiting_time = OTW'(wait_t);
			r.turnaround_time = OTW'(tat_t);
			if (k == held - 1) begin
				r.avg_waiting_q8 = AVW'((64'(wsum) << FRW) / 64'(held));
				r.avg_turnaround_q8 = AVW'((64'(tsum) << FRW) / 64'(held));
				r.last_result = 1'b1;
			end
			schedule_q.push_back(r);
		end
	endtask

	task automatic compare_word(sjf_pkg::sched_t want, sjf_pkg::sched_t got);
		bit bad;
		bad = (got.process_number !== want.process_number) ||
		      (got.start_time !== want.start_time) ||
		      (got.waiting_time !== want.waiting_time) ||
		      (got.turnaround_time !== want.turnaround_time) ||
		      (got.avg_waiting_q8 !== want.avg_waiting_q8) ||
		      (got.avg_turnaround_q8 !== want.avg_turnaround_q8) ||
		      (got.last_result !== want.last_result);
		if (bad) begin
			errs++;
			if (errs <= REPORT_LIMIT) begin
				$display("word %0d expected: proc %0d start %0d wait %0d tat %0d avg %0d/%0d last %0b",
				         words_checked, want.process_number, want.start_time, want.waiting_time,
				         want.turnaround_time, want.avg_waiting_q8, want.avg_turnaround_q8,
				         want.last_result);
				$display("word %0d actual:   proc %0d start %0d wait %0d tat %0d avg %0d/%0d last %0b",
				         words_checked, got.process_number, got.start_time, got.waiting_time,
				         got.turnaround_time, got.avg_waiting_q8, got.avg_turnaround_q8,
				         got.last_result);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sjf_pkg::sched_t want;
		if (!arst_n) begin
			held = 0;
			errs = 0;
			words_checked = 0;
			schedule_q.delete();
			fail_count <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			if (job_valid && job_ready) begin
				// Words past a full set are dropped, but a final one still starts the run.
				if (held < NPROC) begin
					arr_q[held] = job.arrival_time;
					burst_q[held] = job.burst_time;
					held++;
				end
				if (job.last_process) begin
					plan_schedule();
					held = 0;
				end
			end
			if (sched_valid && sched_ready) begin
				words_checked++;
				if (schedule_q.size() == 0) begin
					errs++;
					if (errs <= REPORT_LIMIT)
						$display("word %0d arrived with nothing expected: proc %0d start %0d",
						         words_checked, sched.process_number, sched.start_time);
				end else begin
					want = schedule_q.pop_front();
					compare_word(want, sched);
				end
			end
			fail_count <= errs;
			pending <= schedule_q.size();
			checked <= words_checked;
		end
	end

endmodule

FILE: tb/sv/testbench.sv
// Top of the scheduler testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module testbench;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int TAIL_CYCLES = 400;
	localparam int RANDOM_WORDS = 350;
	localparam int TW = sjf_pkg::IN_TIME_W;

	typedef enum int {MIX_CROWDED, MIX_WIDE, MIX_LATE, MIX_SPARSE} set_mix_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic job_valid = 1'b0;
	logic job_ready;
	sjf_pkg::job_t job = '0;
	logic sched_valid;
	logic sched_ready = 1'b0;
	sjf_pkg::sched_t sched;

	int fail_count;
	int pending;
	int checked;
	int send_idle_pct = 38;
	int recv_idle_pct = 77;
	int words_sent = 0;
	int runs_sent = 0;
	int cycles = 0;

	sjf_nonpreemptive_scheduler_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (job_valid),
		.job_ready   (job_ready),
		.job         (job),
		.sched_valid (sched_valid),
		.sched_ready (sched_ready),
		.sched       (sched)
	);

	sjf_schedule_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (job_valid),
		.job_ready   (job_ready),
		.job         (job),
		.sched_valid (sched_valid),
		.sched_ready (sched_ready),
		.sched       (sched),
		.fail_count  (fail_count),
		.pending     (pending),
		.checked     (checked)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		sched_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("Timed out with %0d schedule words still outstanding.", pending);
			$display("sjf_nonpreemptive_scheduler_core: mismatch");
			$finish;
		end
	end

	task automatic send_job(input logic [TW-1:0] arrival,
	                        input logic [TW-1:0] burst, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			job_valid <= 1'b0;
			@(posedge clk);
		end
		job_valid <= 1'b1;
		job <= '{arrival_time: arrival, burst_time: burst, last_process: last};
		do @(posedge clk); while (!job_ready);
		words_sent++;
		if (last)
			runs_sent++;
	endtask

	task automatic send_random_set();
		int size;
		set_mix_e mix;
		logic [TW-1:0] a, b;
		// Now and then a set overflows the store so the extra words get dropped.
		size = ($urandom_range(9) == 0) ? int'($urandom_range(20, 17)) :
		       int'($urandom_range(16, 1));
		mix = set_mix_e'($urandom_range(3));
		for (int i = 0; i < size; i++) begin
			case (mix)
			MIX_CROWDED: begin
				a = TW'($urandom_range(40));
				b = TW'($urandom_range(20));
			end
			MIX_WIDE: begin
				a = TW'($urandom);
				b = TW'($urandom);
			end
			MIX_LATE: begin
				a = TW'($urandom_range(65535, 65500));
				b = $urandom_range(1) ? 16'hFFFF : TW'($urandom_range(3));
			end
			default: begin
				a = TW'($urandom);
				b = TW'($urandom_range(100));
			end
			endcase
			send_job(a, b, i == size - 1);
		end
	endtask

	initial begin
		int directed_words;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Lone processes at both ends of the time range.
		send_job(16'h0000, 16'h0000, 1'b1);
		send_job(16'hFFFF, 16'hFFFF, 1'b1);
		// Burst ties broken by arrival and by load order, with an idle gap before time 100.
		send_job(16'd0, 16'd5, 1'b0);
		send_job(16'd100, 16'd3, 1'b0);
		send_job(16'd100, 16'd3, 1'b0);
		send_job(16'd2, 16'd5, 1'b0);
		send_job(16'd1, 16'd5, 1'b1);
		// A full set of maximum bursts, then a final word that is dropped but starts the run.
		for (int i = 0; i < 16; i++)
			send_job(16'h0000, 16'hFFFF, 1'b0);
		send_job(16'd1234, 16'd1, 1'b1);
		directed_words = words_sent;

		while (words_sent < directed_words + RANDOM_WORDS) begin
			if (words_sent >= directed_words + 2 * RANDOM_WORDS / 3) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (words_sent >= directed_words + RANDOM_WORDS / 3) begin
				send_idle_pct = 77;
				recv_idle_pct = 38;
			end
			send_random_set();
		end
		job_valid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d process words in %0d sets, with ties, idle gaps and overflow;",
		         words_sent, runs_sent);
		$display("compared %0d schedule words under three stall patterns.", checked);
		if (fail_count == 0)
			$display("sjf_nonpreemptive_scheduler_core: match");
		else
			$display("sjf_nonpreemptive_scheduler_core: mismatch");
		$finish;
	end

endmodule

FILE: sjf_nonpreemptive_scheduler_core.f
rtl/sjf_pkg.sv
rtl/sjf_nonpreemptive_scheduler_core.sv
tb/sv/sjf_schedule_checker.sv
tb/sv/testbench.sv
